// ----- design/agls_pkg.sv -----
// ----------------------------------------------------------------------------
// agls_pkg
// Shared types and constants of the ASAP gate layer scheduler: gate and
// result payloads, register indexes, controller states and datapath ops.
// ----------------------------------------------------------------------------
package agls_pkg;

    localparam int DEF_MAX_QUBITS = 64;
    localparam int DEF_MAX_LAYERS = 1024;

    localparam int QUBIT_W = 6;
    localparam int LAYER_W = 11;
    localparam int NQ_W    = 7;
    localparam int CAP_W   = 13;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam logic [NQ_W-1:0]  NQ_RESET  = 7'd64;
    localparam logic [CAP_W-1:0] CAP_RESET = 13'd1;

    typedef enum logic [1:0] {
        MODE_SINGLE  = 2'd0,
        MODE_PAIR    = 2'd1,
        MODE_GLOBAL  = 2'd2,
        MODE_BARRIER = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_QUBIT = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

    typedef enum logic {
        REG_NUM_QUBITS = 1'b0,
        REG_MAX_GATES  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_mode                mode;
        logic [QUBIT_W-1:0]   qubit_a;
        logic [QUBIT_W-1:0]   qubit_b;
    } t_gate;

    typedef struct packed {
        logic [LAYER_W-1:0]   layer;
        logic [QUBIT_W-1:0]   qubit_low;
        logic [QUBIT_W-1:0]   qubit_high;
        logic [LAYER_W-1:0]   layer_total;
        t_err                 error;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_COMMIT,
        S_PAIR_WB,
        S_MAX,
        S_MAX_END,
        S_ALIGN,
        S_SWEEP,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_QERR,
        OP_SINGLE,
        OP_PAIR_INIT,
        OP_SCAN_RD,
        OP_SCAN_NEXT,
        OP_PAIR_COMMIT,
        OP_PAIR_WB,
        OP_FULL,
        OP_MAX_INIT,
        OP_MAX_RD,
        OP_ALIGN,
        OP_BAR_OPEN,
        OP_SWEEP_WR
    } t_dp_op;

    typedef struct packed {
        t_mode  mode;
        logic   qubit_err;
        logic   scan_end;
        logic   fill_full;
        logic   table_full;
        logic   cnt_last;
        logic   lsn;
    } t_dp_status;

endpackage

// ----- design/agls_ctrl.sv -----
// ----------------------------------------------------------------------------
// agls_ctrl
// Scheduler controller: sequences decode, layer scan, frontier sweeps and
// the result strobe, and issues one datapath op per cycle.
// ----------------------------------------------------------------------------
module agls_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  agls_pkg::t_dp_status   i_status,
    output logic                   o_busy,
    output logic                   o_res_valid,
    output agls_pkg::t_dp_op       o_op
);
    import agls_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_status.mode)
                    MODE_SINGLE: n_state = S_DONE;
                    MODE_PAIR: begin
                        n_state = i_status.qubit_err ? S_DONE : S_SCAN_RD;
                    end
                    default: n_state = S_MAX;
                endcase
            end
            S_SCAN_RD: begin
                n_state = i_status.scan_end ? S_COMMIT : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                n_state = i_status.fill_full ? S_SCAN_RD : S_COMMIT;
            end
            S_COMMIT: begin
                if (i_status.scan_end && i_status.table_full) n_state = S_DONE;
                else n_state = S_PAIR_WB;
            end
            S_PAIR_WB: n_state = S_DONE;
            S_MAX: begin
                if (i_status.cnt_last) n_state = S_MAX_END;
            end
            S_MAX_END: n_state = S_ALIGN;
            S_ALIGN: begin
                if (i_status.mode == MODE_BARRIER && i_status.lsn && i_status.table_full) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (i_status.cnt_last) n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_busy      = (r_state != S_IDLE);
        o_res_valid = (r_state == S_DONE);
        o_op        = OP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_start) o_op = OP_ACCEPT;
            end
            S_DECODE: begin
                case (i_status.mode)
                    MODE_SINGLE: o_op = i_status.qubit_err ? OP_QERR : OP_SINGLE;
                    MODE_PAIR:   o_op = i_status.qubit_err ? OP_QERR : OP_PAIR_INIT;
                    default:     o_op = OP_MAX_INIT;
                endcase
            end
            S_SCAN_RD: begin
                if (!i_status.scan_end) o_op = OP_SCAN_RD;
            end
            S_SCAN_CHK: begin
                if (i_status.fill_full) o_op = OP_SCAN_NEXT;
            end
            S_COMMIT: begin
                if (i_status.scan_end && i_status.table_full) o_op = OP_FULL;
                else o_op = OP_PAIR_COMMIT;
            end
            S_PAIR_WB: o_op = OP_PAIR_WB;
            S_MAX:     o_op = OP_MAX_RD;
            S_ALIGN: begin
                if (i_status.mode == MODE_BARRIER && i_status.lsn) begin
                    o_op = i_status.table_full ? OP_FULL : OP_BAR_OPEN;
                end else begin
                    o_op = OP_ALIGN;
                end
            end
            S_SWEEP: o_op = OP_SWEEP_WR;
            default: o_op = OP_NOP;
        endcase
    end

endmodule

// ----- design/agls_dp.sv -----
// ----------------------------------------------------------------------------
// agls_dp
// Scheduler datapath: qubit frontier memory with valid bits, layer fill
// memory, layer count, and the result registers.
// ----------------------------------------------------------------------------
module agls_dp #(
    parameter int MAX_QUBITS = agls_pkg::DEF_MAX_QUBITS,
    parameter int MAX_LAYERS = agls_pkg::DEF_MAX_LAYERS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  agls_pkg::t_dp_op              i_op,
    input  agls_pkg::t_gate               i_gate,
    input  logic [agls_pkg::NQ_W-1:0]     i_num_qubits,
    input  logic [agls_pkg::CAP_W-1:0]    i_max_gates,
    output agls_pkg::t_dp_status          o_status,
    output agls_pkg::t_result             o_result
);
    import agls_pkg::*;

    localparam int QW = $clog2(MAX_QUBITS);
    localparam int NW = $clog2(MAX_QUBITS + 1);
    localparam int CW = (NW > NQ_W) ? NW : NQ_W;
    localparam int LW = $clog2(MAX_LAYERS + 1);
    localparam int FW = $clog2(MAX_LAYERS);

    // frontier memory; an entry never written reads as zero
    logic [LW-1:0]          r_front_mem [MAX_QUBITS];
    logic [MAX_QUBITS-1:0]  r_front_vld;
    logic [LW-1:0]          r_rda;
    logic [LW-1:0]          r_rdb;
    logic                   r_vla;
    logic                   r_vlb;

    // fill memory; entries at or above the layer count are never read
    logic [CAP_W-1:0]       r_fill_mem [MAX_LAYERS];
    logic [CAP_W-1:0]       r_fill_q;

    t_mode                  r_mode,  n_mode;
    logic [QUBIT_W-1:0]     r_qa,    n_qa;
    logic [QUBIT_W-1:0]     r_qb,    n_qb;
    logic [LW-1:0]          r_l,     n_l;
    logic [LW-1:0]          r_max,   n_max;
    logic [LW-1:0]          r_open,  n_open;
    logic [LW-1:0]          r_layer, n_layer;
    logic [NW-1:0]          r_cnt,   n_cnt;
    logic                   r_pend,  n_pend;
    logic                   r_lsn,   n_lsn;
    t_err                   r_err,   n_err;
    logic [QUBIT_W-1:0]     r_lo,    n_lo;
    logic [QUBIT_W-1:0]     r_hi,    n_hi;

    logic [CW-1:0]          nq_raw;
    logic [CW-1:0]          nq_clamp;
    logic [NW-1:0]          nq;
    logic [CAP_W-1:0]       cap;
    logic [CW-1:0]          qa_ext, qb_ext, ga_ext, gb_ext;
    logic [QW-1:0]          qa_idx, qb_idx, ga_idx, gb_idx, cnt_idx;
    logic [LW-1:0]          fa, fb, front_max, l_sel, open_inc;
    logic [NW-1:0]          cnt_inc;
    logic                   new_layer;
    logic                   qerr;

    logic                   rda_en;
    logic [QW-1:0]          rda_addr;
    logic                   fw_en;
    logic [QW-1:0]          fw_addr;
    logic [LW-1:0]          fw_data;
    logic                   lw_en;
    logic [FW-1:0]          lw_addr;
    logic [CAP_W-1:0]       lw_data;

    always_comb begin
        nq_raw = CW'(i_num_qubits);
        if (nq_raw == '0) begin
            nq_clamp = CW'(1);
        end else if (nq_raw > CW'(MAX_QUBITS)) begin
            nq_clamp = CW'(MAX_QUBITS);
        end else begin
            nq_clamp = nq_raw;
        end
    end

    assign nq  = NW'(nq_clamp);
    assign cap = (i_max_gates == '0) ? CAP_W'(1) : i_max_gates;

    assign qa_ext  = CW'(r_qa);
    assign qb_ext  = CW'(r_qb);
    assign ga_ext  = CW'(i_gate.qubit_a);
    assign gb_ext  = CW'(i_gate.qubit_b);
    assign qa_idx  = qa_ext[QW-1:0];
    assign qb_idx  = qb_ext[QW-1:0];
    assign ga_idx  = ga_ext[QW-1:0];
    assign gb_idx  = gb_ext[QW-1:0];
    assign cnt_idx = r_cnt[QW-1:0];

    assign fa        = r_vla ? r_rda : '0;
    assign fb        = r_vlb ? r_rdb : '0;
    assign front_max = (fa > fb) ? fa : fb;
    assign new_layer = (r_l >= r_open);
    assign l_sel     = new_layer ? r_open : r_l;
    assign open_inc  = r_open + LW'(1);
    assign cnt_inc   = r_cnt + NW'(1);

    assign qerr = (qa_ext >= nq_clamp) ||
                  ((r_mode == MODE_PAIR) && ((qb_ext >= nq_clamp) || (r_qa == r_qb)));

    // frontier memory ports
    assign rda_en   = (i_op == OP_ACCEPT) || (i_op == OP_MAX_RD);
    assign rda_addr = (i_op == OP_ACCEPT) ? ga_idx : cnt_idx;

    always_comb begin
        fw_en   = 1'b0;
        fw_addr = qa_idx;
        fw_data = r_max;
        case (i_op)
            OP_PAIR_COMMIT: begin
                fw_en   = 1'b1;
                fw_addr = qa_idx;
                fw_data = l_sel + LW'(1);
            end
            OP_PAIR_WB: begin
                fw_en   = 1'b1;
                fw_addr = qb_idx;
                fw_data = r_l + LW'(1);
            end
            OP_SWEEP_WR: begin
                fw_en   = 1'b1;
                fw_addr = cnt_idx;
                fw_data = r_max;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fw_en) r_front_mem[fw_addr] <= fw_data;
        if (rda_en) begin
            r_rda <= r_front_mem[rda_addr];
            r_vla <= r_front_vld[rda_addr];
        end
        if (i_op == OP_ACCEPT) begin
            r_rdb <= r_front_mem[gb_idx];
            r_vlb <= r_front_vld[gb_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_vld <= '0;
        end else if (fw_en) begin
            r_front_vld[fw_addr] <= 1'b1;
        end
    end

    // fill memory ports; a newly opened layer starts from zero
    always_comb begin
        lw_en   = 1'b0;
        lw_addr = l_sel[FW-1:0];
        lw_data = '0;
        case (i_op)
            OP_PAIR_COMMIT: begin
                lw_en   = 1'b1;
                lw_addr = l_sel[FW-1:0];
                lw_data = new_layer ? CAP_W'(1) : r_fill_q + CAP_W'(1);
            end
            OP_BAR_OPEN: begin
                lw_en   = 1'b1;
                lw_addr = r_open[FW-1:0];
                lw_data = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (lw_en) r_fill_mem[lw_addr] <= lw_data;
        if (i_op == OP_SCAN_RD) r_fill_q <= r_fill_mem[r_l[FW-1:0]];
    end

    always_comb begin
        n_mode  = r_mode;
        n_qa    = r_qa;
        n_qb    = r_qb;
        n_l     = r_l;
        n_open  = r_open;
        n_layer = r_layer;
        n_cnt   = r_cnt;
        n_lsn   = r_lsn;
        n_err   = r_err;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_pend  = (i_op == OP_MAX_RD);
        n_max   = r_max;
        // fold the frontier read issued last cycle
        if (r_pend && (fa > r_max)) n_max = fa;
        case (i_op)
            OP_ACCEPT: begin
                n_mode = i_gate.mode;
                n_qa   = i_gate.qubit_a;
                n_qb   = i_gate.qubit_b;
            end
            OP_QERR: begin
                n_layer = '0;
                n_err   = ERR_QUBIT;
                n_lo    = '0;
                n_hi    = '0;
            end
            OP_SINGLE: begin
                n_layer = fa;
                n_err   = ERR_OK;
                n_lo    = '0;
                n_hi    = '0;
                if (fa == r_open) n_lsn = 1'b1;
            end
            OP_PAIR_INIT: n_l = front_max;
            OP_SCAN_NEXT: n_l = r_l + LW'(1);
            OP_PAIR_COMMIT: begin
                n_l     = l_sel;
                n_layer = l_sel;
                n_err   = ERR_OK;
                n_lo    = (r_qa < r_qb) ? r_qa : r_qb;
                n_hi    = (r_qa < r_qb) ? r_qb : r_qa;
                if (new_layer) begin
                    n_open = open_inc;
                    n_lsn  = 1'b0;
                end
            end
            OP_FULL: begin
                n_layer = '0;
                n_err   = ERR_FULL;
                n_lo    = '0;
                n_hi    = '0;
            end
            OP_MAX_INIT: begin
                n_max = '0;
                n_cnt = '0;
            end
            OP_MAX_RD: n_cnt = cnt_inc;
            OP_ALIGN: begin
                n_layer = r_max;
                n_err   = ERR_OK;
                n_lo    = '0;
                n_hi    = '0;
                n_cnt   = '0;
                if ((r_mode == MODE_GLOBAL) && (r_max == r_open)) n_lsn = 1'b1;
            end
            OP_BAR_OPEN: begin
                n_open  = open_inc;
                n_lsn   = 1'b0;
                n_max   = r_max + LW'(1);
                n_layer = r_max + LW'(1);
                n_err   = ERR_OK;
                n_lo    = '0;
                n_hi    = '0;
                n_cnt   = '0;
            end
            OP_SWEEP_WR: n_cnt = cnt_inc;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
            r_lsn  <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_open <= n_open;
            r_lsn  <= n_lsn;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_qa    <= n_qa;
        r_qb    <= n_qb;
        r_l     <= n_l;
        r_max   <= n_max;
        r_layer <= n_layer;
        r_cnt   <= n_cnt;
        r_err   <= n_err;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
    end

    assign o_status.mode       = r_mode;
    assign o_status.qubit_err  = qerr;
    assign o_status.scan_end   = new_layer;
    assign o_status.fill_full  = (r_fill_q >= cap);
    assign o_status.table_full = (r_open >= LW'(MAX_LAYERS));
    assign o_status.cnt_last   = (cnt_inc == nq);
    assign o_status.lsn        = r_lsn;

    assign o_result.layer       = LAYER_W'(r_layer);
    assign o_result.qubit_low   = r_lo;
    assign o_result.qubit_high  = r_hi;
    assign o_result.layer_total = LAYER_W'(r_open);
    assign o_result.error       = r_err;

endmodule

// ----- design/asap_gate_layer_scheduler.sv -----
// ----------------------------------------------------------------------------
// asap_gate_layer_scheduler
// Places each gate in its earliest layer: per-qubit frontiers, per-layer
// pair counts, and frontier alignment for global gates and barriers.
// ----------------------------------------------------------------------------
//  channel   signals                                  transaction at
//  gate      start, busy, i_gate                      start && !busy
//  result    o_res_valid, o_result                    o_res_valid (one cycle)
//  config    psel, penable, pwrite, paddr, pwdata,    psel && penable && pwrite
//            prdata, pready
//
//  A single gate or a qubit error goes from decode straight to the strobe;
//  a pair scans layers upward from its frontier, with one fill memory read
//  per full layer skipped, then commits and writes back both frontiers.
//  Global gates and barriers take one frontier read sweep over the clamped
//  qubit count and one write sweep, unless a barrier finds the table full.
//  busy drops the cycle after the strobe. Reset needs no clearing pass. The receiver cannot stall.
module asap_gate_layer_scheduler #(
    parameter int MAX_QUBITS = agls_pkg::DEF_MAX_QUBITS,
    parameter int MAX_LAYERS = agls_pkg::DEF_MAX_LAYERS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  agls_pkg::t_gate                 i_gate,
    output logic                            o_res_valid,
    output agls_pkg::t_result               o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [agls_pkg::APB_AW-1:0]     paddr,
    input  logic [agls_pkg::APB_DW-1:0]     pwdata,
    output logic [agls_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import agls_pkg::*;

    logic [NQ_W-1:0]    r_num_qubits;
    logic [CAP_W-1:0]   r_max_gates;
    t_reg_idx           reg_idx;
    logic               cfg_wr;
    t_dp_op             dp_op;
    t_dp_status         dp_status;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_qubits <= NQ_RESET;
            r_max_gates  <= CAP_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_NUM_QUBITS: r_num_qubits <= pwdata[NQ_W-1:0];
                REG_MAX_GATES:  r_max_gates  <= pwdata[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_NUM_QUBITS: prdata = APB_DW'(r_num_qubits);
            REG_MAX_GATES:  prdata = APB_DW'(r_max_gates);
            default:        prdata = '0;
        endcase
    end

    agls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_status    (dp_status),
        .o_busy      (busy),
        .o_res_valid (o_res_valid),
        .o_op        (dp_op)
    );

    agls_dp #(
        .MAX_QUBITS (MAX_QUBITS),
        .MAX_LAYERS (MAX_LAYERS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (dp_op),
        .i_gate       (i_gate),
        .i_num_qubits (r_num_qubits),
        .i_max_gates  (r_max_gates),
        .o_status     (dp_status),
        .o_result     (o_result)
    );

`ifndef SYNTH
    a_strobe_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> busy)
        else $error("result strobe outside a busy transaction");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted gate did not raise busy");

    a_full_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_result.error == ERR_FULL))
            |-> (o_result.layer_total == LAYER_W'(MAX_LAYERS)))
        else $error("table full reported below the layer limit");
`endif

endmodule
